@@ sv/kpd_pkg.sv @@
package kpd_pkg;

    // Matrix geometry; the snapshot carries at most 16 key bits.
    localparam int ROWS = 4;
    localparam int COLS = 4;
    localparam int KEY_BITS = 16;
    localparam int SCAN_BITS = (ROWS * COLS < KEY_BITS) ? ROWS * COLS : KEY_BITS;

    localparam logic [6:0] ASCII_A = 7'd65;

    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic       RST_ENABLED  = 1'b1;
    localparam logic [7:0] RST_DEBOUNCE = 8'd2;
    localparam logic [15:0] RST_LONG    = 16'd100;
    localparam logic [7:0] RST_PERIOD   = 8'd10;

    typedef enum logic [1:0] {
        CFG_ENABLED  = 2'd0,
        CFG_DEBOUNCE = 2'd1,
        CFG_LONG     = 2'd2,
        CFG_PERIOD   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_DEBOUNCE = 3'd1,
        PH_PRESSED  = 3'd2,
        PH_LONG     = 3'd3,
        PH_RELEASE  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_SHORT   = 2'd1,
        EV_LONG    = 2'd2,
        EV_RELEASE = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_ACTIVE = 2'd1,
        ST_LONG   = 2'd2
    } t_status;

    typedef enum logic {
        REQ_SCAN  = 1'b0,
        REQ_CLEAR = 1'b1
    } t_req;

    typedef struct packed {
        logic        req_type;
        logic [15:0] pressed_keys;
    } t_in;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [4:0]  event_key;
        logic [6:0]  event_value;
        logic [6:0]  held_value;
        logic [2:0]  fsm_state;
        logic [1:0]  key_row;
        logic [1:0]  key_col;
        logic [4:0]  key_index;
        logic [23:0] hold_time_ms;
        logic [1:0]  status_event;
    } t_out;

    // Chosen key of one snapshot
    typedef struct packed {
        logic       found;
        logic [2:0] row;
        logic [2:0] col;
    } t_pick;

    function automatic logic [6:0] index_of(logic [2:0] r, logic [2:0] c);
        return 7'(int'(r) * COLS + int'(c) + 1);
    endfunction

endpackage

@@ sv/kpd_stream_if.sv @@
interface kpd_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/kpd_pick.sv @@
module kpd_pick (
    input  logic [15:0]     i_keys,
    output kpd_pkg::t_pick  o_pick
);
    import kpd_pkg::*;

    // Walk from the highest bit down so the lowest row/column wins.
    always_comb begin
        o_pick = '0;
        for (int k = SCAN_BITS - 1; k >= 0; k--) begin
            if (i_keys[k]) begin
                o_pick.found = 1'b1;
                o_pick.row   = 3'(k / COLS);
                o_pick.col   = 3'(k % COLS);
            end
        end
    end

endmodule

@@ sv/kpd_core.sv @@
module kpd_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [kpd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_step,
    input  kpd_pkg::t_in                      i_item,
    output kpd_pkg::t_out                     o_result
);
    import kpd_pkg::*;

    logic        r_enabled;
    logic [7:0]  r_debounce;
    logic [15:0] r_long_ticks;
    logic [7:0]  r_period;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_row, n_row;
    logic [2:0]  r_col, n_col;
    logic [6:0]  r_index, n_index;
    logic [15:0] r_hold, n_hold;
    logic [7:0]  r_match, n_match;
    logic        r_long_fired, n_long_fired;
    logic [6:0]  r_stored, n_stored;

    t_pick       pick;
    logic        same_key;
    logic [6:0]  tracked_index;
    t_event      ev;
    logic [6:0]  ev_key;
    logic [6:0]  ev_val;
    t_status     status;

    kpd_pick u_pick (
        .i_keys (i_item.pressed_keys),
        .o_pick (pick)
    );

    assign same_key      = pick.found && pick.row == r_row && pick.col == r_col;
    assign tracked_index = index_of(r_row, r_col);

    always_comb begin
        n_phase      = r_phase;
        n_row        = r_row;
        n_col        = r_col;
        n_index      = r_index;
        n_hold       = r_hold;
        n_match      = r_match;
        n_long_fired = r_long_fired;
        n_stored     = r_stored;
        ev           = EV_NONE;
        ev_key       = '0;
        ev_val       = '0;

        if (i_item.req_type == REQ_CLEAR) begin
            n_stored = '0;
        end else if (r_enabled) begin
            unique case (r_phase)
                PH_DEBOUNCE: begin
                    if (same_key) begin
                        if (r_match != 8'hFF) begin
                            n_match = r_match + 8'd1;
                        end
                        if (n_match >= r_debounce) begin
                            n_index      = tracked_index;
                            n_hold       = '0;
                            n_long_fired = 1'b0;
                            n_stored     = '0;
                            n_phase      = PH_PRESSED;
                            ev           = EV_SHORT;
                            ev_key       = tracked_index;
                            ev_val       = tracked_index;
                        end
                    end else begin
                        n_phase = PH_IDLE;
                        n_match = '0;
                    end
                end
                PH_PRESSED: begin
                    if (same_key) begin
                        if (r_hold != 16'hFFFF) begin
                            n_hold = r_hold + 16'd1;
                        end
                        if (!r_long_fired && n_hold >= r_long_ticks) begin
                            n_long_fired = 1'b1;
                            n_stored     = ASCII_A + {2'b00, tracked_index[6:2]};
                            n_phase      = PH_LONG;
                            ev           = EV_LONG;
                            ev_key       = r_index;
                            ev_val       = n_stored;
                        end
                    end else begin
                        if (!r_long_fired) begin
                            n_stored = r_index;
                        end
                        ev      = EV_RELEASE;
                        ev_key  = r_index;
                        ev_val  = n_stored;
                        n_phase = PH_RELEASE;
                    end
                end
                PH_LONG: begin
                    if (!same_key) begin
                        n_stored     = '0;
                        n_long_fired = 1'b0;
                        n_phase      = PH_RELEASE;
                    end
                end
                PH_RELEASE: begin
                    if (!pick.found) begin
                        n_phase      = PH_IDLE;
                        n_stored     = '0;
                        n_long_fired = 1'b0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    if (pick.found) begin
                        n_row   = pick.row;
                        n_col   = pick.col;
                        n_match = 8'd1;
                        n_phase = PH_DEBOUNCE;
                    end
                end
            endcase
        end
    end

    always_comb begin
        if (n_long_fired) begin
            status = ST_LONG;
        end else if (n_phase == PH_PRESSED || n_phase == PH_RELEASE) begin
            status = ST_ACTIVE;
        end else begin
            status = ST_NONE;
        end
    end

    always_comb begin
        o_result.event_kind   = ev;
        o_result.event_key    = ev_key[4:0];
        o_result.event_value  = ev_val;
        o_result.held_value   = n_stored;
        o_result.fsm_state    = n_phase;
        o_result.key_row      = n_row[1:0];
        o_result.key_col      = n_col[1:0];
        o_result.key_index    = n_index[4:0];
        o_result.hold_time_ms = 24'(n_hold) * 24'(r_period);
        o_result.status_event = status;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled    <= RST_ENABLED;
            r_debounce   <= RST_DEBOUNCE;
            r_long_ticks <= RST_LONG;
            r_period     <= RST_PERIOD;
            r_phase      <= PH_IDLE;
            r_row        <= '0;
            r_col        <= '0;
            r_index      <= '0;
            r_hold       <= '0;
            r_match      <= '0;
            r_long_fired <= 1'b0;
            r_stored     <= '0;
        end else begin
            if (i_step) begin
                r_phase      <= n_phase;
                r_row        <= n_row;
                r_col        <= n_col;
                r_index      <= n_index;
                r_hold       <= n_hold;
                r_match      <= n_match;
                r_long_fired <= n_long_fired;
                r_stored     <= n_stored;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_ENABLED: begin
                        r_enabled <= i_cfg_data[0];
                        // disabling drops the machine back to idle
                        if (!i_cfg_data[0]) begin
                            r_phase <= PH_IDLE;
                        end
                    end
                    CFG_DEBOUNCE: r_debounce   <= i_cfg_data[7:0];
                    CFG_LONG:     r_long_ticks <= i_cfg_data[15:0];
                    CFG_PERIOD:   r_period     <= i_cfg_data[7:0];
                endcase
            end
        end
    end

endmodule

@@ sv/matrix_keypad_press_detector.sv @@
// Data path: the input transaction is captured in the input register, and the
// result is then registered in the result register when the output may advance.
// Throughput: one transaction per cycle while the output is not stalled.
// Reset (i_rst_n low, synchronous): machine idle, counters and stored value
// cleared, registers back to enabled=1, debounce 2, long press 100, period 10.
module matrix_keypad_press_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [1:0]                        i_cfg_idx,
    input  logic [kpd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    kpd_stream_if.sink                        i_in,
    kpd_stream_if.source                      o_out
);
    import kpd_pkg::*;

    logic r_in_vld;
    t_in  r_in;
    logic r_out_vld;
    t_out r_out;

    logic advance;
    logic in_ready;
    logic step;
    t_out result;

    assign advance  = !r_out_vld || o_out.ready;
    assign in_ready = !r_in_vld || advance;
    assign step     = r_in_vld && advance;

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_vld;
    assign o_out.data  = r_out;

    kpd_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_step     (step),
        .i_item     (r_in),
        .o_result   (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_ready) begin
                r_in_vld <= i_in.valid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready) begin
            r_in <= i_in.data;
        end
        if (step) begin
            r_out <= result;
        end
    end

endmodule
